### hw/rtl/ssst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssst_pkg;

  // Command codes carried in the low bits of an input beat.
  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SET      = 3'd2,
    CMD_SET_WORD = 3'd3,
    CMD_GET      = 3'd4
  } cmd_e;

  // Configuration register indexes.
  localparam logic [7:0] REG_REQUEST_CODE = 8'd0;
  localparam logic [7:0] REG_EXCLUDE_CODE = 8'd1;

  localparam int CountW = 6;

  // Command and configuration broadcast to every cell during a scan.
  typedef struct packed {
    cmd_e        op;
    logic [31:0] server_id;
    logic [7:0]  new_flag;
    logic [31:0] now;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [7:0]  request_code;
    logic [7:0]  exclude_code;
  } cmd_t;

  // Token that walks the chain one cell per cycle and gathers the result.
  typedef struct packed {
    logic              valid;
    logic              prefix;
    logic              ok;
    logic [7:0]        flag_out;
    logic [CountW-1:0] total_sent;
    logic [CountW-1:0] total_wait;
    logic [31:0]       send_time;
    logic [31:0]       status_time;
    logic [63:0]       word_low;
    logic [63:0]       word_high;
  } carrier_t;

endpackage

`default_nettype wire

### hw/rtl/ssst_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ssst_cell
  import ssst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     cmd,
  input  wire carrier_t c_in,
  output carrier_t      c_out
);

  logic [31:0] id;
  logic [7:0]  flag;
  logic [31:0] send_time;
  logic [31:0] status_time;
  logic [63:0] word_low;
  logic [63:0] word_high;

  logic [31:0] id_next;
  logic [7:0]  flag_next;
  logic [31:0] send_time_next;
  logic [31:0] status_time_next;
  logic [63:0] word_low_next;
  logic [63:0] word_high_next;
  carrier_t    c_next;
  logic        touched;
  logic        live;
  logic        is_match;

  // Apply the command to this slot when the token arrives, then fold the
  // slot's updated contents into the running counts.
  always_comb begin
    id_next          = id;
    flag_next        = flag;
    send_time_next   = send_time;
    status_time_next = status_time;
    word_low_next    = word_low;
    word_high_next   = word_high;
    c_next           = c_in;
    touched          = 1'b0;
    live             = 1'b0;
    is_match = c_in.prefix && !c_in.ok && (id != 32'd0) && (id == cmd.server_id);

    if (c_in.valid) begin
      unique case (cmd.op) inside
        CMD_CLEAR: begin
          id_next          = '0;
          flag_next        = '0;
          send_time_next   = '0;
          status_time_next = '0;
          word_low_next    = '0;
          word_high_next   = '0;
        end
        CMD_ADD: begin
          if (!c_in.ok && (id == 32'd0)) begin
            id_next          = cmd.server_id;
            flag_next        = cmd.request_code;
            send_time_next   = cmd.now;
            status_time_next = cmd.now;
            c_next.ok        = 1'b1;
            touched          = 1'b1;
          end
        end
        CMD_SET, CMD_SET_WORD: begin
          if (is_match) begin
            flag_next        = cmd.new_flag;
            status_time_next = cmd.now;
            if (cmd.op == CMD_SET_WORD) begin
              word_low_next  = cmd.word_low;
              word_high_next = cmd.word_high;
            end
            c_next.ok = 1'b1;
            touched   = 1'b1;
          end
        end
        CMD_GET: begin
          if (is_match) begin
            c_next.flag_out = flag;
            c_next.ok       = 1'b1;
            touched         = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Readback of the slot that the command touched.
      if (touched) begin
        c_next.send_time   = send_time_next;
        c_next.status_time = status_time_next;
        c_next.word_low    = word_low_next;
        c_next.word_high   = word_high_next;
      end

      // The filled prefix ends at the first slot that is empty afterwards.
      live          = c_in.prefix && (id_next != 32'd0);
      c_next.prefix = live;
      if (live && (flag_next != cmd.exclude_code)) begin
        c_next.total_sent = c_in.total_sent + CountW'(1);
      end
      if (live && (flag_next == cmd.request_code)) begin
        c_next.total_wait = c_in.total_wait + CountW'(1);
      end
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      id          <= '0;
      flag        <= '0;
      send_time   <= '0;
      status_time <= '0;
      word_low    <= '0;
      word_high   <= '0;
    end else begin
      id          <= id_next;
      flag        <= flag_next;
      send_time   <= send_time_next;
      status_time <= status_time_next;
      word_low    <= word_low_next;
      word_high   <= word_high_next;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_out <= '0;
    end else begin
      c_out <= c_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/server_slot_status_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat launches a token into the chain head register.
// The token walks the chain of slot cells one cell per cycle, then waits in the
// holding stage for the output register, and s_tready rises again only once it
// has moved on. A stalled output register holds the input off as well.
// Reset empties every slot and sets request_code to 1 and exclude_code to 2.

module server_slot_status_table_core
  import ssst_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // cmd, server_id, new_flag, now, word_low, word_high, zero pad
  input  wire logic [207:0] s_tdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // ok, flag_out, total_sent, total_wait, send_time_out, status_time_out,
  // word_low_out, word_high_out, zero pad
  output logic [215:0]      m_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  logic [7:0] request_code;
  logic [7:0] exclude_code;
  cmd_t       cmd;
  logic       busy;
  carrier_t   chain [SLOTS+1];
  carrier_t   head;
  carrier_t   pend;
  carrier_t   res;
  logic       accept;
  logic       advance;
  logic [SLOTS:0] token_vec;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !busy && !pend.valid;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      request_code <= 8'd1;
      exclude_code <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REQUEST_CODE: request_code <= cfg_data;
        REG_EXCLUDE_CODE: exclude_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Command held for the whole walk; the two codes track the config registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op        <= cmd_e'(s_tdata[2:0]);
      cmd.server_id <= s_tdata[34:3];
      cmd.new_flag  <= s_tdata[42:35];
      cmd.now       <= s_tdata[74:43];
      cmd.word_low  <= s_tdata[138:75];
      cmd.word_high <= s_tdata[202:139];
    end
    cmd.request_code <= request_code;
    cmd.exclude_code <= exclude_code;
  end

  // Token launched into the chain head for an accepted command.
  always_comb begin
    head        = '0;
    head.valid  = accept;
    head.prefix = accept;
    head.ok     = accept && (s_tdata[2:0] == CMD_CLEAR);
  end

  // Token injection at the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
      busy     <= 1'b0;
    end else begin
      chain[0] <= head;
      if (accept) begin
        busy <= 1'b1;
      end else if (chain[SLOTS].valid) begin
        busy <= 1'b0;
      end
    end
  end

  // One cell per slot.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ssst_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .c_in  (chain[i]),
      .c_out (chain[i+1])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_token
    assign token_vec[i] = chain[i].valid;
  end

  // Result leaves the chain into a holding stage, then the output register.
  assign advance = pend.valid && (!res.valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      res  <= '0;
    end else begin
      if (chain[SLOTS].valid) begin
        pend <= chain[SLOTS];
      end else if (advance) begin
        pend.valid <= 1'b0;
      end
      if (advance) begin
        res <= pend;
      end else if (m_tready) begin
        res.valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = res.valid;
  assign m_tdata  = {3'b000, res.word_high, res.word_low, res.status_time, res.send_time,
                     res.total_wait, res.total_sent, res.flag_out, res.ok};

`ifndef NO_ASSERTIONS
  // Only one command token is ever in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(token_vec))
    else $error("more than one token in the slot chain");

  // A token reaching the end of the chain finds the holding stage free.
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    chain[SLOTS].valid |-> !pend.valid)
    else $error("result overwrote a pending result");

  // An accepted command starts a walk at the chain head.
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && chain[0].valid))
    else $error("accepted command did not start a scan");

  // A token only leaves the end of the chain while a scan is running.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    chain[SLOTS].valid |-> busy)
    else $error("token left the chain outside a scan");
`endif

endmodule

`default_nettype wire
